// File: sv/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, constants and helpers of the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int ADDR_W       = 64;
  localparam int OP_W         = 3;
  localparam int CFG_W        = 9;
  localparam int STAT_W       = 2;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd16;

  localparam int PAGES        = 4096;
  localparam int PAGE_W       = $clog2(PAGES);
  localparam int PG_SHIFT     = 12;
  localparam int PAGES_PER_MB = 256;

  // Bitmap is held as words of WORD_W page bits.
  localparam int WORD_W       = 64;
  localparam int IDX_W        = $clog2(WORD_W);
  localparam int WORDS        = PAGES / WORD_W;
  localparam int WADDR_W      = $clog2(WORDS);
  localparam int PTR_W        = WADDR_W + 1;
  localparam int MB_WORDS     = PAGES_PER_MB / WORD_W;

  localparam logic [ADDR_W-1:0] VBASE = 64'hffff_ffff_8000_0000;

  // Region bounds in pages; all are multiples of the word width.
  localparam int PAGING_LO  = 0;
  localparam int TASKS_LO   = 1280;
  localparam int STACK_LO   = 2304;
  localparam int KMALLOC_LO = 2560;
  localparam int GENERAL_LO = 2816;

  typedef enum logic [OP_W-1:0] {
    OP_INIT          = 3'd0,
    OP_ALLOC_GENERAL = 3'd1,
    OP_ALLOC_PAGING  = 3'd2,
    OP_ALLOC_TASKS   = 3'd3,
    OP_ALLOC_STACK   = 3'd4,
    OP_ALLOC_KMALLOC = 3'd5,
    OP_FREE          = 3'd6
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    WR_ONES,
    WR_CLEAR,
    WR_SET
  } wr_sel_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INIT_WR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SCAN_WR,
    S_FREE_WR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic    load;
    logic    wptr_inc;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    find;
    logic    take;
    logic    set_empty;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    more;
    logic    found;
    logic    oor;
  } dp_status_t;

  function automatic logic [PTR_W-1:0] region_lo(opcode_e op);
    logic [PTR_W-1:0] lo;
    case (op)
      OP_ALLOC_GENERAL: lo = PTR_W'(GENERAL_LO / WORD_W);
      OP_ALLOC_TASKS:   lo = PTR_W'(TASKS_LO / WORD_W);
      OP_ALLOC_STACK:   lo = PTR_W'(STACK_LO / WORD_W);
      OP_ALLOC_KMALLOC: lo = PTR_W'(KMALLOC_LO / WORD_W);
      default:          lo = PTR_W'(PAGING_LO / WORD_W);
    endcase
    return lo;
  endfunction

  function automatic logic [PTR_W-1:0] region_hi(opcode_e op);
    logic [PTR_W-1:0] hi;
    case (op)
      OP_ALLOC_PAGING:  hi = PTR_W'(TASKS_LO / WORD_W);
      OP_ALLOC_TASKS:   hi = PTR_W'(STACK_LO / WORD_W);
      OP_ALLOC_STACK:   hi = PTR_W'(KMALLOC_LO / WORD_W);
      OP_ALLOC_KMALLOC: hi = PTR_W'(GENERAL_LO / WORD_W);
      default:          hi = '0;
    endcase
    return hi;
  endfunction

  // Encode a one-hot word into the index of its set bit.
  function automatic logic [IDX_W-1:0] oh_to_idx(logic [WORD_W-1:0] oh);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int j = 0; j < WORD_W; j++) begin
      if (oh[j]) begin
        idx = idx | IDX_W'(j);
      end
    end
    return idx;
  endfunction

endpackage

// File: sv/pba_ram.sv
// ----------------------------------------------------------------------------
// pba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pba_ram #(
  parameter int DATA_W = 64,
  parameter int DEPTH  = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: sv/pba_datapath.sv
// ----------------------------------------------------------------------------
// pba_datapath
// Bitmap word store, word pointer, first-fit bit pick and result registers.
// ----------------------------------------------------------------------------
module pba_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [pba_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic [pba_pkg::OP_W-1:0]    opcode_i,
  input  logic [pba_pkg::ADDR_W-1:0]  address_i,
  input  pba_pkg::ctrl_cmd_t          cmd_i,
  output pba_pkg::dp_status_t         status_o,
  output logic [pba_pkg::ADDR_W-1:0]  page_address_o,
  output logic [pba_pkg::STAT_W-1:0]  status_code_o
);
  import pba_pkg::*;

  logic [CFG_W-1:0]  total_mb_q;
  opcode_e           op_q;
  logic              oor_q;
  logic [IDX_W-1:0]  fbit_q;
  logic [PTR_W-1:0]  wptr_q, wptr_d;
  logic [PTR_W-1:0]  hi_q, hi_d;
  logic [WORDS-1:0]  row_valid_q;
  logic              rvalid_q;
  logic [WORD_W-1:0] word_q, mask_q;
  status_e           res_status_q;
  logic [ADDR_W-1:0] res_addr_q;
  status_e           out_status_q;
  logic [ADDR_W-1:0] out_addr_q;

  logic [WORD_W-1:0] ram_rdata, rd_word, wr_data;
  logic [15:0]       mb_words;
  logic [PTR_W-1:0]  cfg_hi;
  logic [PAGE_W-1:0] page;
  logic [ADDR_W-1:0] take_addr;
  logic              in_oor;
  opcode_e           in_op;

  pba_ram #(
    .DATA_W (WORD_W),
    .DEPTH  (WORDS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.wr_en),
    .wr_addr_i (wptr_q[WADDR_W-1:0]),
    .wr_data_i (wr_data),
    .rd_addr_i (wptr_q[WADDR_W-1:0]),
    .rd_data_o (ram_rdata)
  );

  // Page count in words, clamped to the bitmap size.
  assign mb_words = 16'(total_mb_q) * 16'(MB_WORDS);
  assign cfg_hi   = (mb_words > 16'(WORDS)) ? PTR_W'(WORDS) : mb_words[PTR_W-1:0];

  assign in_op  = opcode_e'(opcode_i);
  assign in_oor = (address_i[ADDR_W-1:PG_SHIFT+PAGE_W] != '0);

  // A row never written reads as all used.
  assign rd_word = rvalid_q ? ram_rdata : '0;

  always_comb begin
    case (cmd_i.wr_sel)
      WR_ONES:  wr_data = '1;
      WR_CLEAR: wr_data = word_q & ~mask_q;
      WR_SET:   wr_data = rd_word | (WORD_W'(1) << fbit_q);
      default:  wr_data = '1;
    endcase
  end

  assign page      = {wptr_q[WADDR_W-1:0], oh_to_idx(mask_q)};
  assign take_addr = (ADDR_W'(page) << PG_SHIFT) |
                     ((op_q inside {OP_ALLOC_STACK, OP_ALLOC_KMALLOC}) ? VBASE : '0);

  always_comb begin
    if (cmd_i.load) begin
      case (in_op)
        OP_INIT, OP_ALLOC_GENERAL: hi_d = cfg_hi;
        default:                   hi_d = region_hi(in_op);
      endcase
      if (in_op == OP_FREE) begin
        wptr_d = PTR_W'(address_i[PG_SHIFT+PAGE_W-1:PG_SHIFT+IDX_W]);
      end else begin
        wptr_d = region_lo(in_op);
      end
    end else begin
      hi_d   = hi_q;
      wptr_d = cmd_i.wptr_inc ? wptr_q + PTR_W'(1) : wptr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_mb_q   <= CFG_RESET;
      row_valid_q  <= '0;
      rvalid_q     <= 1'b0;
      wptr_q       <= '0;
      hi_q         <= '0;
    end else begin
      if (cfg_valid_i) begin
        total_mb_q <= cfg_data_i;
      end
      if (cmd_i.wr_en) begin
        row_valid_q[wptr_q[WADDR_W-1:0]] <= 1'b1;
      end
      rvalid_q <= row_valid_q[wptr_q[WADDR_W-1:0]];
      wptr_q   <= wptr_d;
      hi_q     <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q         <= in_op;
      oor_q        <= in_oor;
      fbit_q       <= address_i[PG_SHIFT+IDX_W-1:PG_SHIFT];
      res_status_q <= (in_op == OP_FREE && in_oor) ? ST_RANGE : ST_DONE;
      res_addr_q   <= '0;
    end else if (cmd_i.set_empty) begin
      res_status_q <= ST_EMPTY;
    end else if (cmd_i.take) begin
      res_addr_q   <= take_addr;
    end
    if (cmd_i.find) begin
      word_q <= rd_word;
      // Isolate the lowest free page of the word.
      mask_q <= rd_word & (~rd_word + WORD_W'(1));
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
    end
  end

  assign status_o.op    = op_q;
  assign status_o.more  = (wptr_q < hi_q);
  assign status_o.found = (rd_word != '0);
  assign status_o.oor   = oor_q;

  assign page_address_o = out_addr_q;
  assign status_code_o  = out_status_q;

`ifndef NO_ASSERTIONS
  a_clear_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_en && cmd_i.wr_sel == WR_CLEAR |-> $onehot(mask_q))
    else $error("page pick mask is not one-hot");

  a_wptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wptr_q <= PTR_W'(WORDS))
    else $error("word pointer past end of bitmap");
`endif

endmodule

// File: sv/pba_ctrl.sv
// ----------------------------------------------------------------------------
// pba_ctrl
// Sequencer for init sweep, first-fit scan, free update and result handoff.
// ----------------------------------------------------------------------------
module pba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  pba_pkg::dp_status_t status_i,
  output pba_pkg::ctrl_cmd_t  cmd_o
);
  import pba_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status_i.op)
          OP_INIT: state_d = S_INIT_WR;
          OP_ALLOC_GENERAL, OP_ALLOC_PAGING, OP_ALLOC_TASKS,
          OP_ALLOC_STACK, OP_ALLOC_KMALLOC: state_d = S_SCAN_RD;
          OP_FREE: state_d = status_i.oor ? S_RESP : S_FREE_WR;
          default: state_d = S_RESP;
        endcase
      end
      S_INIT_WR: begin
        if (status_i.more) begin
          cmd_o.wr_en    = 1'b1;
          cmd_o.wr_sel   = WR_ONES;
          cmd_o.wptr_inc = 1'b1;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SCAN_RD: begin
        if (status_i.more) begin
          state_d = S_SCAN_CHK;
        end else begin
          cmd_o.set_empty = 1'b1;
          state_d         = S_RESP;
        end
      end
      S_SCAN_CHK: begin
        if (status_i.found) begin
          cmd_o.find = 1'b1;
          state_d    = S_SCAN_WR;
        end else begin
          cmd_o.wptr_inc = 1'b1;
          state_d        = S_SCAN_RD;
        end
      end
      S_SCAN_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_CLEAR;
        cmd_o.take   = 1'b1;
        state_d      = S_RESP;
      end
      S_FREE_WR: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SET;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & out_stall_i);
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = (state_q != S_IDLE);

endmodule

// File: sv/page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Bitmap page-frame allocator with first-fit search over fixed regions.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o, opcode_i, address_i): one
//   transaction is one request. A request is taken only while no other is
//   in progress; in_stall_o stays high from the cycle after acceptance until
//   the result is handed to the output register.
//   Output channel (out_valid_o / out_stall_i, page_address_o, status_o): one
//   transaction per request, in request order. The output register holds a
//   result while out_stall_i is high, and the next request is already taken
//   and worked on meanwhile.
//   Configuration channel (cfg_valid_i / cfg_ready_o, cfg_data_i): writes
//   total_mb; always ready, write it only when no request is in flight.
// Each request is served by a one-word-per-step walk over the 64-bit bitmap RAM
// with its registered read: free writes one word, out-of-range free and unused
// opcode skip the bitmap, init writes every word below the page count, and
// allocate scans the region's words up to the first free page (all, if empty).
// A new request is taken only after the last result reaches the output register.
// Reset: bitmap reads as all pages used (per-row valid flops), total_mb = 16.
// ----------------------------------------------------------------------------
module page_bitmap_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [pba_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [pba_pkg::OP_W-1:0]   opcode_i,
  input  logic [pba_pkg::ADDR_W-1:0] address_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [pba_pkg::ADDR_W-1:0] page_address_o,
  output logic [pba_pkg::STAT_W-1:0] status_o
);
  import pba_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_status;
  logic       cfg_write;

  // Register writes need no wait state.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i & cfg_ready_o;

  // Sequence each request: decode, walk words, write back, hand off.
  pba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (cmd)
  );

  // Hold the bitmap, the config register and the result registers.
  pba_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_write),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .address_i      (address_i),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .page_address_o (page_address_o),
    .status_code_o  (status_o)
  );

`ifndef NO_ASSERTIONS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one still in progress");

  a_fail_zero_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DONE |-> page_address_o == '0)
    else $error("failed request returned a nonzero address");
`endif

endmodule

// File: tb/page_bitmap_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator_tb
// Self-checking bench for the page bitmap allocator. A shadow copy of the
// free-page bitmap and of total_mb computes the page address and status of
// every accepted request. The monitor compares each result transaction with
// the oldest pending reply. Stimulus opens with directed corner requests and
// then runs random traffic under several memory sizes, with bursty requests
// and a wandering output stall.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_tb;
  import pba_pkg::*;

  // Opcode 7 has no meaning in the block and must behave as a no-op.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  // Slowest legal item: an init over the whole bitmap, the longest request
  // gap and the longest output stall. Some 1900 items are run; allow several
  // times their total run time.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 265;
  localparam int REPORT_LINES = 40;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
  } request_t;

  typedef struct {
    logic [ADDR_W-1:0] page_address;
    logic [STAT_W-1:0] status;
  } reply_t;

  typedef enum int {
    STALL_NONE,
    STALL_SPARSE,
    STALL_LONG
  } stall_mode_e;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CFG_W-1:0]  cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [OP_W-1:0]   opcode_i = OP_INIT;
  logic [ADDR_W-1:0] address_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ADDR_W-1:0] page_address_o;
  logic [STAT_W-1:0] status_o;

  // Shadow state of the block.
  bit               free_map [PAGES];
  logic [CFG_W-1:0] installed_mb = CFG_RESET;

  request_t pending_reqs [$];
  reply_t   replies_due [$];
  int       requests_queued = 0;
  int       requests_accepted = 0;
  int       mismatch_count = 0;
  int       cycle_count = 0;

  int burst_left = 0;
  int gap_left = 0;

  stall_mode_e stall_mode = STALL_NONE;
  int          stall_run = 0;
  int          stall_cycle = 0;

  int mb_plan [7] = '{256, 0, 11, 12, 3, 1, 16};

  page_bitmap_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .page_address_o (page_address_o),
    .status_o       (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Serve one request against the shadow bitmap: update it and return the
  // reply the block must give. First fit, lowest page of the region wins.
  function automatic reply_t serve_page_request(logic [OP_W-1:0] op,
                                                logic [ADDR_W-1:0] addr);
    reply_t            r;
    int                npages;
    int                lo;
    int                hi;
    int                p;
    bit                virt;
    bit                is_alloc;
    bit                hit;
    logic [ADDR_W-1:0] pn;
    r.page_address = '0;
    r.status = ST_DONE;
    npages = int'(installed_mb) * PAGES_PER_MB;
    if (npages > PAGES) begin
      npages = PAGES;
    end
    lo = 0;
    hi = 0;
    virt = 1'b0;
    is_alloc = 1'b1;
    case (op)
      OP_INIT: begin
        // Pages at or above the page count keep their bits.
        for (p = 0; p < npages; p++) begin
          free_map[p] = 1'b1;
        end
        is_alloc = 1'b0;
      end
      OP_ALLOC_GENERAL: begin
        lo = GENERAL_LO;
        hi = npages;
      end
      OP_ALLOC_PAGING: begin
        lo = PAGING_LO;
        hi = TASKS_LO;
      end
      OP_ALLOC_TASKS: begin
        lo = TASKS_LO;
        hi = STACK_LO;
      end
      OP_ALLOC_STACK: begin
        lo = STACK_LO;
        hi = KMALLOC_LO;
        virt = 1'b1;
      end
      OP_ALLOC_KMALLOC: begin
        lo = KMALLOC_LO;
        hi = GENERAL_LO;
        virt = 1'b1;
      end
      OP_FREE: begin
        // Freeing an already free page or one above the page count is legal.
        pn = addr >> PG_SHIFT;
        if (pn >= ADDR_W'(PAGES)) begin
          r.status = ST_RANGE;
        end else begin
          free_map[pn[PAGE_W-1:0]] = 1'b1;
        end
        is_alloc = 1'b0;
      end
      default: begin
        is_alloc = 1'b0;
      end
    endcase
    if (is_alloc) begin
      hit = 1'b0;
      for (p = lo; p < hi && !hit; p++) begin
        if (free_map[p]) begin
          free_map[p] = 1'b0;
          r.page_address = ADDR_W'(p) << PG_SHIFT;
          if (virt) begin
            r.page_address = r.page_address | VBASE;
          end
          hit = 1'b1;
        end
      end
      if (!hit) begin
        r.status = ST_EMPTY;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    if (mismatch_count < REPORT_LINES) begin
      $display("%0t ns  %s: got %h, want %h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic queue_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
    request_t req;
    req.op = op;
    req.addr = addr;
    pending_reqs.push_back(req);
    requests_queued++;
  endtask

  // Free a page with random offset bits inside the page.
  task automatic queue_free_page(int pg);
    queue_request(OP_FREE, (ADDR_W'(pg) << PG_SHIFT) | ADDR_W'($urandom_range(0, 4095)));
  endtask

  // Hold until every queued request is accepted and every reply checked.
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (requests_accepted != requests_queued || replies_due.size() != 0);
  endtask

  task automatic write_total_mb(logic [CFG_W-1:0] mb);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= mb;
    do begin
      @(posedge clk_i);
    end while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    installed_mb = mb;
  endtask

  // Random mix: mostly allocations and in-range frees, spread over every
  // region, with a few inits, out-of-range frees and unused opcodes.
  task automatic queue_random_traffic(int count);
    int k;
    int pick;
    int region;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        queue_request(OP_INIT, {$urandom, $urandom});
      end else if (pick < 6) begin
        queue_request(OP_UNUSED, {$urandom, $urandom});
      end else if (pick < 62) begin
        queue_request(OP_W'($urandom_range(OP_ALLOC_GENERAL, OP_ALLOC_KMALLOC)),
                      {$urandom, $urandom});
      end else if (pick < 92) begin
        region = $urandom_range(0, 4);
        case (region)
          0:       queue_free_page($urandom_range(PAGING_LO, TASKS_LO - 1));
          1:       queue_free_page($urandom_range(TASKS_LO, STACK_LO - 1));
          2:       queue_free_page($urandom_range(STACK_LO, KMALLOC_LO - 1));
          3:       queue_free_page($urandom_range(KMALLOC_LO, GENERAL_LO - 1));
          default: queue_free_page($urandom_range(GENERAL_LO, PAGES - 1));
        endcase
      end else begin
        queue_request(OP_FREE, {$urandom, $urandom});
      end
    end
  endtask

  // Request driver: present pending requests in bursts, hold a stalled
  // transaction, and compute the reply at the edge that accepts it.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    request_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        replies_due.push_back(serve_page_request(opcode_i, address_i));
        requests_accepted++;
      end
      // The slot frees when nothing is offered or the offer was just taken.
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          opcode_i <= nxt.op;
          address_i <= nxt.addr;
          // Close the burst on its last item: pick the gap and the next burst.
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
            gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 4);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted result against the oldest reply and
  // drive the output stall. The stall mode wanders between no stall, sparse
  // random stalls and long stall runs.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    reply_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_run = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result with no request pending", page_address_o, '0);
        end else begin
          want = replies_due.pop_front();
          if (page_address_o !== want.page_address) begin
            report_mismatch("page_address", page_address_o, want.page_address);
          end
          if (status_o !== want.status) begin
            report_mismatch("status", ADDR_W'(status_o), ADDR_W'(want.status));
          end
        end
      end
      stall_cycle++;
      if (stall_cycle % 256 == 0) begin
        stall_mode = stall_mode_e'($urandom_range(STALL_NONE, STALL_LONG));
      end
      if (stall_run > 0) begin
        stall_run--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_SPARSE: out_stall_i <= ($urandom_range(0, 2) == 0);
          STALL_LONG: begin
            if ($urandom_range(0, 9) == 0) begin
              stall_run = $urandom_range(5, 30);
              out_stall_i <= 1'b1;
            end else begin
              out_stall_i <= 1'b0;
            end
          end
          default: out_stall_i <= 1'b0;
        endcase
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int ph;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, under the reset size of 16 MiB (all 4096 pages).
    // Every region is empty straight out of reset.
    queue_request(OP_ALLOC_GENERAL, '0);
    queue_request(OP_ALLOC_PAGING, '1);
    queue_request(OP_ALLOC_TASKS, '0);
    queue_request(OP_ALLOC_STACK, '1);
    queue_request(OP_ALLOC_KMALLOC, '0);
    // Out-of-range frees: all ones, then the first page past the bitmap.
    queue_request(OP_FREE, '1);
    queue_request(OP_FREE, ADDR_W'(PAGES) << PG_SHIFT);
    // Free the very last page and take it back through the general region.
    queue_request(OP_FREE, (ADDR_W'(PAGES) << PG_SHIFT) - 1);
    queue_request(OP_ALLOC_GENERAL, '0);
    queue_request(OP_UNUSED, '1);
    queue_request(OP_INIT, '1);
    queue_request(OP_ALLOC_PAGING, '0);
    queue_request(OP_ALLOC_TASKS, '0);
    queue_request(OP_ALLOC_STACK, '0);
    queue_request(OP_ALLOC_KMALLOC, '0);
    queue_request(OP_ALLOC_GENERAL, '0);
    // Free page 0 twice (offset bits set, then clear) and reallocate it.
    queue_request(OP_FREE, ADDR_W'(12'hfff));
    queue_request(OP_FREE, '0);
    queue_request(OP_ALLOC_PAGING, '0);
    // Free the last page of kmalloc and of stack, then allocate from both again.
    queue_free_page(GENERAL_LO - 1);
    queue_free_page(KMALLOC_LO - 1);
    queue_request(OP_ALLOC_STACK, '0);
    queue_request(OP_ALLOC_KMALLOC, '0);
    wait_idle();

    // Random part, one phase per memory size: full and clamped, none,
    // exactly the fixed regions, barely a general region, and small sizes
    // where only frees populate the upper regions.
    for (ph = 0; ph < 7; ph++) begin
      write_total_mb(CFG_W'(mb_plan[ph]));
      if ($urandom_range(0, 1) == 1) begin
        queue_request(OP_INIT, {$urandom, $urandom});
      end
      queue_random_traffic(ITEMS_PER_PHASE);
      wait_idle();
    end

    // Let any stray result surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && replies_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
